// ===== hdl/ccdp_pkg.sv =====
`default_nettype none

package ccdp_pkg;

    // record kinds
    localparam logic [1:0] KIND_TOP = 2'd0;
    localparam logic [1:0] KIND_COMP = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;

    // control byte flags
    localparam logic [7:0] FLAG_BITRATE = 8'h20;
    localparam logic [7:0] FLAG_COMPONENTS = 8'h10;

    // output queue geometry
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       first_byte;
        logic       last_byte;
        logic       outer_ok;
    } t_in_item;

    typedef struct packed {
        logic [1:0] record_kind;
        logic [7:0] comp_tag;
        logic [1:0] recording_control;
        logic       bitrate_present;
        logic [7:0] max_bitrate;
        logic [3:0] user_bits;
        logic       parse_valid;
        logic       last_record;
    } t_out_item;

    // records produced by one accepted byte, slot 0 first
    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  rec0;
        t_out_item  rec1;
    } t_push;

endpackage

`default_nettype wire

// ===== hdl/ccdp_parse.sv =====
`default_nettype none

module ccdp_parse (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire ccdp_pkg::t_in_item i_item,
    output ccdp_pkg::t_push        o_push
);

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_TOPRATE = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_TAG     = 3'd3,
        PH_CONTROL = 3'd4,
        PH_CRATE   = 3'd5,
        PH_NOMORE  = 3'd6,
        PH_ERROR   = 3'd7
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_still_valid, n_still_valid;
    logic        r_has_comps, n_has_comps;
    logic [7:0]  r_decl_len, n_decl_len;
    logic [7:0]  r_bytes_after, n_bytes_after;
    logic [7:0]  r_pend_tag, n_pend_tag;
    logic [5:0]  r_pend_ctrl, n_pend_ctrl;

    t_phase              ph;
    logic                rec_a;
    ccdp_pkg::t_out_item a_item;
    ccdp_pkg::t_out_item end_item;
    logic [7:0]          b;
    logic                ok;

    // one byte of the parse
    always_comb begin
        b = i_item.payload_byte;
        n_phase = r_phase;
        n_still_valid = r_still_valid;
        n_has_comps = r_has_comps;
        n_decl_len = r_decl_len;
        n_bytes_after = r_bytes_after;
        n_pend_tag = r_pend_tag;
        n_pend_ctrl = r_pend_ctrl;
        rec_a = 1'b0;
        a_item = '0;
        end_item = '0;
        ok = 1'b0;

        // framing checks
        if (i_item.first_byte) begin
            n_phase = PH_HEADER;
            n_still_valid = 1'b1;
            n_has_comps = 1'b0;
            n_decl_len = '0;
            n_bytes_after = '0;
            n_pend_tag = '0;
            n_pend_ctrl = '0;
            if (!i_item.outer_ok) begin
                n_still_valid = 1'b0;
                n_phase = PH_ERROR;
            end
        end else if (r_phase == PH_HEADER) begin
            n_still_valid = 1'b0;
            n_phase = PH_ERROR;
        end

        ph = n_phase;
        unique case (ph)
            PH_HEADER: begin
                n_pend_ctrl = {b[7:6], b[3:0]};
                n_has_comps = (b & ccdp_pkg::FLAG_COMPONENTS) != 8'd0;
                if ((b & ccdp_pkg::FLAG_BITRATE) != 8'd0) begin
                    n_phase = PH_TOPRATE;
                end else begin
                    rec_a = 1'b1;
                    a_item.record_kind = ccdp_pkg::KIND_TOP;
                    a_item.recording_control = b[7:6];
                    a_item.user_bits = b[3:0];
                    n_phase = n_has_comps ? PH_LENGTH : PH_NOMORE;
                end
            end
            PH_TOPRATE: begin
                rec_a = 1'b1;
                a_item.record_kind = ccdp_pkg::KIND_TOP;
                a_item.recording_control = n_pend_ctrl[5:4];
                a_item.user_bits = n_pend_ctrl[3:0];
                a_item.bitrate_present = 1'b1;
                a_item.max_bitrate = b;
                n_phase = n_has_comps ? PH_LENGTH : PH_NOMORE;
            end
            PH_LENGTH: begin
                n_decl_len = b;
                n_bytes_after = '0;
                n_phase = PH_TAG;
            end
            PH_TAG, PH_CONTROL, PH_CRATE: begin
                if (n_bytes_after == n_decl_len) begin
                    n_still_valid = 1'b0;
                    n_phase = PH_ERROR;
                end else begin
                    n_bytes_after = n_bytes_after + 8'd1;
                    if (ph == PH_TAG) begin
                        n_pend_tag = b;
                        n_phase = PH_CONTROL;
                    end else if (ph == PH_CONTROL) begin
                        n_pend_ctrl = {b[7:6], b[3:0]};
                        if ((b & ccdp_pkg::FLAG_BITRATE) != 8'd0) begin
                            n_phase = PH_CRATE;
                        end else begin
                            rec_a = 1'b1;
                            a_item.record_kind = ccdp_pkg::KIND_COMP;
                            a_item.comp_tag = n_pend_tag;
                            a_item.recording_control = b[7:6];
                            a_item.user_bits = b[3:0];
                            n_phase = PH_TAG;
                        end
                    end else begin
                        rec_a = 1'b1;
                        a_item.record_kind = ccdp_pkg::KIND_COMP;
                        a_item.comp_tag = n_pend_tag;
                        a_item.recording_control = n_pend_ctrl[5:4];
                        a_item.user_bits = n_pend_ctrl[3:0];
                        a_item.bitrate_present = 1'b1;
                        a_item.max_bitrate = b;
                        n_phase = PH_TAG;
                    end
                end
            end
            PH_NOMORE: begin
                n_still_valid = 1'b0;
                n_phase = PH_ERROR;
            end
            PH_ERROR: begin
            end
            default: begin
            end
        endcase

        // end status on the last byte
        ok = n_still_valid && (n_phase == PH_NOMORE ||
             (n_phase == PH_TAG && n_bytes_after == n_decl_len));
        end_item.record_kind = ccdp_pkg::KIND_END;
        end_item.parse_valid = ok;
        end_item.last_record = 1'b1;

        if (i_item.last_byte) begin
            n_phase = PH_HEADER;
            n_still_valid = 1'b1;
            n_has_comps = 1'b0;
            n_decl_len = '0;
            n_bytes_after = '0;
            n_pend_tag = '0;
            n_pend_ctrl = '0;
        end

        // pack records into queue slots
        o_push = '0;
        if (rec_a) begin
            o_push.rec0 = a_item;
            if (i_item.last_byte) begin
                o_push.rec1 = end_item;
                o_push.cnt = 2'd2;
            end else begin
                o_push.rec0.last_record = 1'b1;
                o_push.cnt = 2'd1;
            end
        end else if (i_item.last_byte) begin
            o_push.rec0 = end_item;
            o_push.cnt = 2'd1;
        end
        if (!i_accept) begin
            o_push.cnt = 2'd0;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
            r_still_valid <= 1'b1;
            r_has_comps <= 1'b0;
            r_decl_len <= '0;
            r_bytes_after <= '0;
            r_pend_tag <= '0;
            r_pend_ctrl <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_still_valid <= n_still_valid;
            r_has_comps <= n_has_comps;
            r_decl_len <= n_decl_len;
            r_bytes_after <= n_bytes_after;
            r_pend_tag <= n_pend_tag;
            r_pend_ctrl <= n_pend_ctrl;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ccdp_outq.sv =====
`default_nettype none

module ccdp_outq (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ccdp_pkg::t_push     i_push,
    output logic                     o_room,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output ccdp_pkg::t_out_item      o_out_item
);

    localparam int unsigned AW = ccdp_pkg::QUEUE_AW;
    localparam int unsigned CW = AW + 1;

    ccdp_pkg::t_out_item r_mem [ccdp_pkg::QUEUE_DEPTH];
    logic [AW-1:0]       r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]       r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]       r_count, n_count;
    logic                pop;
    logic [AW-1:0]       wr_ptr1;

    // room for two records from one transaction
    assign o_room = r_count <= CW'(ccdp_pkg::QUEUE_DEPTH - 2);
    assign o_out_valid = r_count != '0;
    assign o_out_item = r_mem[r_rd_ptr];
    assign pop = o_out_valid && i_out_ready;
    assign wr_ptr1 = r_wr_ptr + AW'(1);

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = r_wr_ptr + AW'(i_push.cnt);
        n_rd_ptr = pop ? r_rd_ptr + AW'(1) : r_rd_ptr;
        n_count = r_count + CW'(i_push.cnt) - CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count <= n_count;
        end
    end

    // record storage
    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.rec0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.rec1;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/copy_control_descriptor_parser.sv =====
// Copy-control descriptor parser: takes one payload byte per transaction and
// can accept a byte in every cycle; each byte is parsed in the cycle it is
// accepted and its records (none, one or two) are queued and appear on the
// output in order, one record per cycle while the output is ready, the final
// one of a byte marked with last_record. Records wait in a four-entry output
// queue; the input is ready while at least two entries are free, so that a
// byte that yields two records (a completed item on the last byte plus the
// end status) always fits, and a stalled output stops the input once three or
// four records are waiting.
`default_nettype none

module copy_control_descriptor_parser (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire ccdp_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output ccdp_pkg::t_out_item      o_out_item
);

    logic            in_accept;
    ccdp_pkg::t_push push;

    assign in_accept = i_in_valid && o_in_ready;

    // byte parser
    ccdp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_item),
        .o_push   (push)
    );

    // record queue
    ccdp_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

`ifndef SYNTHESIS
    // a last byte always yields an end status
    a_last_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_item.last_byte) |-> (push.cnt != 2'd0))
        else $error("last byte produced no record");

    // output is valid next cycle after a last byte is accepted
    a_last_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_item.last_byte) |=> o_out_valid)
        else $error("no record after last byte");

    // nothing is pushed without a transaction
    a_no_idle_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |-> (push.cnt == 2'd0))
        else $error("record pushed without input transaction");

    // two records only come with a last byte
    a_pair_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push.cnt == 2'd2) |-> (i_in_item.last_byte && push.rec1.record_kind ==
        ccdp_pkg::KIND_END))
        else $error("record pair without end status");
`endif

endmodule

`default_nettype wire
